[rtl/spr_pkg.sv]
`timescale 1ns / 1ps

package spr_pkg;

    // request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } spr_req_code_t;

    // register byte addresses
    localparam logic [7:0] ADDR_DATA      = 8'h40;
    localparam logic [7:0] ADDR_STAT0     = 8'h44;
    localparam logic [7:0] ADDR_STAT1     = 8'h45;
    localparam logic [7:0] ADDR_STAT2     = 8'h46;
    localparam logic [7:0] ADDR_STAT3     = 8'h47;
    localparam logic [7:0] ADDR_MODE_LO   = 8'h48;
    localparam logic [7:0] ADDR_MODE_HI   = 8'h49;
    localparam logic [7:0] ADDR_CTRL_LO   = 8'h4A;
    localparam logic [7:0] ADDR_CTRL_HI   = 8'h4B;
    localparam logic [7:0] ADDR_BAUD_LO   = 8'h4E;
    localparam logic [7:0] ADDR_BAUD_HI   = 8'h4F;

    localparam int TIMER_W   = 21;
    localparam int PENDING_W = 31;

    localparam logic [PENDING_W-1:0] PENDING_MAX = {PENDING_W{1'b1}};
    localparam logic [2:0]           STATUS_SET  = 3'b111;

    // one accepted item as it leaves the input register
    typedef struct packed {
        spr_req_code_t req;
        logic [7:0]    addr;
        logic [7:0]    data;
        logic [15:0]   cycles;
    } spr_req_t;

    // timer reload value: baud * (mode & 3) / 2, rounded down
    function automatic logic [TIMER_W-1:0] reload_value(
        input logic [15:0] baud,
        input logic [1:0]  mode_lo
    );
        logic [17:0] prod;
        begin
            prod = ({2'b00, baud} & {18{mode_lo[0]}})
                 + ({1'b0, baud, 1'b0} & {18{mode_lo[1]}});
            reload_value = {4'b0000, prod[17:1]};
        end
    endfunction

endpackage

[rtl/serial_port_register_block_core.sv]
`timescale 1ns / 1ps

// Byte-wide register block of a serial port. Each item is a byte read, a byte
// write, a tick that adds elapsed cycles to a saturating pending count, or an
// unused code that changes nothing; every item gives exactly one read_data byte
// (zero for writes, ticks and unused codes). A new item is taken every cycle
// while out_ready is high: it is held in the input register, where the register
// file is updated, and its byte then waits in the result register. The input
// stage keeps accepting while the result register drains.
module serial_port_register_block_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  bus_address,
    input  logic [7:0]  write_data,
    input  logic [15:0] elapsed_cycles,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data
);

    logic              held_valid;
    spr_pkg::spr_req_t held_req;
    logic              take;
    logic [7:0]        rd_byte;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;

    // item moves on when the result register is free or draining
    assign take = held_valid && (!out_valid_reg || out_ready);

    spr_input_reg u_input (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .bus_address    (bus_address),
        .write_data     (write_data),
        .elapsed_cycles (elapsed_cycles),
        .take           (take),
        .held_valid     (held_valid),
        .held_req       (held_req)
    );

    spr_reg_file u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (take),
        .req     (held_req),
        .rd_byte (rd_byte)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= held_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            read_data_reg <= rd_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

[rtl/spr_input_reg.sv]
`timescale 1ns / 1ps

module spr_input_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [7:0]        bus_address,
    input  logic [7:0]        write_data,
    input  logic [15:0]       elapsed_cycles,
    input  logic              take,
    output logic              held_valid,
    output spr_pkg::spr_req_t held_req
);

    logic              valid_reg;
    spr_pkg::spr_req_t req_reg;

    // stage is free when empty or when its item moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_req   = req_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.req    <= spr_pkg::spr_req_code_t'(req_type);
            req_reg.addr   <= bus_address;
            req_reg.data   <= write_data;
            req_reg.cycles <= elapsed_cycles;
        end
    end

endmodule

[rtl/spr_reg_file.sv]
`timescale 1ns / 1ps

module spr_reg_file (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  spr_pkg::spr_req_t req,
    output logic [7:0]        rd_byte
);

    logic [spr_pkg::TIMER_W-1:0]   timer_reg,   timer_next;
    logic [spr_pkg::PENDING_W-1:0] pending_reg, pending_next;
    logic [2:0]                    status_reg,  status_next;
    logic [15:0]                   mode_reg,    mode_next;
    logic [15:0]                   ctrl_reg,    ctrl_next;
    logic [15:0]                   baud_reg,    baud_next;
    logic [7:0]                    tx_reg,      tx_next;

    logic [spr_pkg::TIMER_W-1:0]   timer_sync;
    logic [spr_pkg::PENDING_W:0]   pending_sum;
    logic                          is_access;

    assign is_access = (req.req == spr_pkg::REQ_READ) || (req.req == spr_pkg::REQ_WRITE);

    // timer after the pending cycles are taken off, or reloaded if they exceed it
    always_comb
    begin
        if (pending_reg > {{(spr_pkg::PENDING_W-spr_pkg::TIMER_W){1'b0}}, timer_reg})
        begin
            timer_sync = spr_pkg::reload_value(baud_reg, mode_reg[1:0]);
        end
        else
        begin
            timer_sync = timer_reg - pending_reg[spr_pkg::TIMER_W-1:0];
        end
    end

    // saturating pending count
    assign pending_sum = {1'b0, pending_reg}
                       + {{(spr_pkg::PENDING_W-15){1'b0}}, req.cycles};

    // next state and read byte
    always_comb
    begin
        timer_next   = timer_reg;
        pending_next = pending_reg;
        status_next  = status_reg;
        mode_next    = mode_reg;
        ctrl_next    = ctrl_reg;
        baud_next    = baud_reg;
        tx_next      = tx_reg;
        rd_byte      = 8'h00;

        if (is_access)
        begin
            timer_next   = timer_sync;
            pending_next = '0;
        end

        case (req.req)
            spr_pkg::REQ_READ:
            begin
                case (req.addr)
                    spr_pkg::ADDR_STAT0:
                    begin
                        status_next = spr_pkg::STATUS_SET;
                        rd_byte     = {5'b00000, status_reg | spr_pkg::STATUS_SET};
                    end
                    spr_pkg::ADDR_STAT1:   rd_byte = {timer_sync[4:0], 3'b000};
                    spr_pkg::ADDR_STAT2:   rd_byte = timer_sync[12:5];
                    spr_pkg::ADDR_STAT3:   rd_byte = timer_sync[20:13];
                    spr_pkg::ADDR_MODE_LO: rd_byte = mode_reg[7:0];
                    spr_pkg::ADDR_MODE_HI: rd_byte = mode_reg[15:8];
                    spr_pkg::ADDR_CTRL_LO: rd_byte = ctrl_reg[7:0];
                    spr_pkg::ADDR_CTRL_HI: rd_byte = ctrl_reg[15:8];
                    spr_pkg::ADDR_BAUD_LO: rd_byte = baud_reg[7:0];
                    spr_pkg::ADDR_BAUD_HI: rd_byte = baud_reg[15:8];
                    default:               rd_byte = 8'h00;
                endcase
            end
            spr_pkg::REQ_WRITE:
            begin
                case (req.addr)
                    spr_pkg::ADDR_DATA:    tx_next = req.data;
                    spr_pkg::ADDR_MODE_LO: mode_next = {mode_reg[15:8], req.data};
                    spr_pkg::ADDR_MODE_HI: mode_next = {req.data, mode_reg[7:0]};
                    spr_pkg::ADDR_CTRL_LO: ctrl_next = {ctrl_reg[15:8], req.data};
                    spr_pkg::ADDR_CTRL_HI: ctrl_next = {req.data, ctrl_reg[7:0]};
                    spr_pkg::ADDR_BAUD_LO:
                    begin
                        baud_next  = {baud_reg[15:8], req.data};
                        timer_next = spr_pkg::reload_value({baud_reg[15:8], req.data},
                                                           mode_reg[1:0]);
                    end
                    spr_pkg::ADDR_BAUD_HI:
                    begin
                        baud_next  = {req.data, baud_reg[7:0]};
                        timer_next = spr_pkg::reload_value({req.data, baud_reg[7:0]},
                                                           mode_reg[1:0]);
                    end
                    default:
                    begin
                    end
                endcase
            end
            spr_pkg::REQ_TICK:
            begin
                if (pending_sum[spr_pkg::PENDING_W])
                begin
                    pending_next = spr_pkg::PENDING_MAX;
                end
                else
                begin
                    pending_next = pending_sum[spr_pkg::PENDING_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // register state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg   <= '0;
            pending_reg <= '0;
            status_reg  <= '0;
            mode_reg    <= '0;
            ctrl_reg    <= '0;
            baud_reg    <= '0;
            tx_reg      <= '0;
        end
        else if (fire)
        begin
            timer_reg   <= timer_next;
            pending_reg <= pending_next;
            status_reg  <= status_next;
            mode_reg    <= mode_next;
            ctrl_reg    <= ctrl_next;
            baud_reg    <= baud_next;
            tx_reg      <= tx_next;
        end
    end

endmodule

[tb/sv/serial_port_register_block_core_tb.sv]
`timescale 1ns / 1ps

module serial_port_register_block_core_tb;

    localparam int HOLD_CYCLES = 200;

    // one bus item, with an optional hand-written expected byte
    typedef struct {
        spr_pkg::spr_req_code_t kind;
        logic [7:0]             addr;
        logic [7:0]             wdata;
        logic [15:0]            cycles;
        bit                     known;
        logic [7:0]             known_byte;
    } bus_item_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type       = 2'b00;
    logic [7:0]  bus_address    = 8'h00;
    logic [7:0]  write_data     = 8'h00;
    logic [15:0] elapsed_cycles = 16'h0000;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [7:0]  read_data;

    // shadow copy of the register file
    logic [spr_pkg::TIMER_W-1:0]   tmr      = '0;
    logic [2:0]                    flags    = '0;
    logic [15:0]                   mode     = '0;
    logic [15:0]                   ctrl     = '0;
    logic [15:0]                   baud     = '0;
    logic [7:0]                    tx_byte  = '0;
    logic [spr_pkg::PENDING_W-1:0] pend_cnt = '0;

    bus_item_t  stim_q[$];
    logic [7:0] expected_bytes[$];
    bus_item_t  on_bus;
    logic [7:0] want_byte;
    int         mismatch_count = 0;
    int         tx_gap_pct     = 0;
    int         rx_stall_pct   = 0;
    bit         hold_go        = 1'b0;
    logic       rx_hold        = 1'b0;

    // directed items: reset values, byte lanes, timer wrap, unmapped and unused codes
    bus_item_t directed_tbl [0:25] = '{
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_BAUD_HI, 8'h00, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT1,   8'h00, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT0,   8'h00, 16'h0000, 1'b1,
          {5'b00000, spr_pkg::STATUS_SET}},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_MODE_LO, 8'hFF, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_MODE_HI, 8'hFF, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_MODE_LO, 8'h00, 16'h0000, 1'b1, 8'hFF},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_MODE_HI, 8'h00, 16'h0000, 1'b1, 8'hFF},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_CTRL_LO, 8'hA5, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_CTRL_HI, 8'h5A, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_CTRL_LO, 8'h00, 16'h0000, 1'b1, 8'hA5},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_CTRL_HI, 8'h00, 16'h0000, 1'b1, 8'h5A},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_BAUD_LO, 8'hFF, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_BAUD_HI, 8'hFF, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT1,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT2,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT3,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{spr_pkg::REQ_TICK,  8'h00,                 8'h00, 16'hFFFF, 1'b1, 8'h00},
        '{spr_pkg::REQ_TICK,  8'h00,                 8'h00, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT2,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{spr_pkg::REQ_TICK,  8'h00,                 8'h00, 16'hFFFF, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_STAT3,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{spr_pkg::REQ_WRITE, spr_pkg::ADDR_DATA,    8'h3C, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_DATA,    8'h00, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  8'hFF,                 8'h00, 16'h0000, 1'b1, 8'h00},
        '{spr_pkg::REQ_NONE,  spr_pkg::ADDR_MODE_LO, 8'hFF, 16'hFFFF, 1'b1, 8'h00},
        '{spr_pkg::REQ_READ,  spr_pkg::ADDR_BAUD_LO, 8'h00, 16'h0000, 1'b1, 8'hFF}
    };

    serial_port_register_block_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .bus_address    (bus_address),
        .write_data     (write_data),
        .elapsed_cycles (elapsed_cycles),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // timer reload: baud times the low two mode bits, halved
    function automatic logic [spr_pkg::TIMER_W-1:0] timer_reload();
        logic [17:0] prod;
        prod = baud * mode[1:0];
        return {4'b0000, prod[17:1]};
    endfunction

    // byte the block returns for one item, updating the shadow registers
    function automatic logic [7:0] predict_read_data(bus_item_t it);
        logic [31:0] pend_sum;
        logic [7:0]  rd;
        rd = 8'h00;
        // bus accesses first let the timer catch up on pending cycles
        if (it.kind == spr_pkg::REQ_READ || it.kind == spr_pkg::REQ_WRITE)
        begin
            if (pend_cnt > tmr)
                tmr = timer_reload();
            else
                tmr = tmr - pend_cnt[spr_pkg::TIMER_W-1:0];
            pend_cnt = '0;
        end
        case (it.kind)
            spr_pkg::REQ_READ:
            begin
                case (it.addr)
                    spr_pkg::ADDR_STAT0:
                    begin
                        flags = spr_pkg::STATUS_SET;
                        rd = {5'b00000, flags};
                    end
                    spr_pkg::ADDR_STAT1:   rd = {tmr[4:0], 3'b000};
                    spr_pkg::ADDR_STAT2:   rd = tmr[12:5];
                    spr_pkg::ADDR_STAT3:   rd = tmr[20:13];
                    spr_pkg::ADDR_MODE_LO: rd = mode[7:0];
                    spr_pkg::ADDR_MODE_HI: rd = mode[15:8];
                    spr_pkg::ADDR_CTRL_LO: rd = ctrl[7:0];
                    spr_pkg::ADDR_CTRL_HI: rd = ctrl[15:8];
                    spr_pkg::ADDR_BAUD_LO: rd = baud[7:0];
                    spr_pkg::ADDR_BAUD_HI: rd = baud[15:8];
                    default:               rd = 8'h00;
                endcase
            end
            spr_pkg::REQ_WRITE:
            begin
                case (it.addr)
                    spr_pkg::ADDR_DATA:    tx_byte = it.wdata;
                    spr_pkg::ADDR_MODE_LO: mode[7:0] = it.wdata;
                    spr_pkg::ADDR_MODE_HI: mode[15:8] = it.wdata;
                    spr_pkg::ADDR_CTRL_LO: ctrl[7:0] = it.wdata;
                    spr_pkg::ADDR_CTRL_HI: ctrl[15:8] = it.wdata;
                    spr_pkg::ADDR_BAUD_LO:
                    begin
                        baud[7:0] = it.wdata;
                        tmr = timer_reload();
                    end
                    spr_pkg::ADDR_BAUD_HI:
                    begin
                        baud[15:8] = it.wdata;
                        tmr = timer_reload();
                    end
                    default: ;
                endcase
            end
            spr_pkg::REQ_TICK:
            begin
                // pending count saturates instead of wrapping
                pend_sum = {1'b0, pend_cnt} + it.cycles;
                pend_cnt = (pend_sum > spr_pkg::PENDING_MAX) ? spr_pkg::PENDING_MAX
                                                             : pend_sum[spr_pkg::PENDING_W-1:0];
            end
            default: ;
        endcase
        return rd;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        $display("mismatch: %s got %02h expected %02h at %0t", what, got, want, $time);
    endtask

    // queue random items, weighted toward the register address range 0x40 to 0x4F
    task automatic fill_random(int n);
        bus_item_t it;
        int        pick;
        int        counted;
        counted = 0;
        while (counted < n)
        begin
            pick = $urandom_range(99);
            it.kind = (pick < 45) ? spr_pkg::REQ_READ : (pick < 72) ? spr_pkg::REQ_WRITE :
                      (pick < 95) ? spr_pkg::REQ_TICK : spr_pkg::REQ_NONE;
            if ($urandom_range(9) < 7)
                it.addr = 8'(spr_pkg::ADDR_DATA + $urandom_range(15));
            else
                it.addr = 8'($urandom_range(255));
            it.wdata = 8'($urandom_range(255));
            pick = $urandom_range(9);
            if (pick < 5)
                it.cycles = 16'($urandom_range(255));
            else if (pick < 8)
                it.cycles = 16'($urandom_range(4095));
            else
                it.cycles = 16'($urandom_range(65535));
            it.known = 1'b0;
            it.known_byte = 8'h00;
            stim_q.push_back(it);
            counted++;
        end
    endtask

    // wait until every item is taken and every byte has come back
    task automatic wait_idle();
        while (stim_q.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    // item handshake, result check and next drive, in one place per edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // item taken by the block
            if (in_valid && in_ready)
            begin
                want_byte = predict_read_data(on_bus);
                expected_bytes.push_back(on_bus.known ? on_bus.known_byte : want_byte);
            end
            // result leaving the block
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("read_data with no item outstanding", read_data, 8'h00);
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (read_data !== want_byte)
                        report_mismatch("read_data", read_data, want_byte);
                end
            end
            // next item, with random gaps
            if (!in_valid || in_ready)
            begin
                if (stim_q.size() != 0 && $urandom_range(99) >= tx_gap_pct)
                begin
                    on_bus = stim_q.pop_front();
                    in_valid       <= 1'b1;
                    req_type       <= on_bus.kind;
                    bus_address    <= on_bus.addr;
                    write_data     <= on_bus.wdata;
                    elapsed_cycles <= on_bus.cycles;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_tbl[i])
            stim_q.push_back(directed_tbl[i]);
        wait_idle();

        // random items under each idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_gap_pct = 64;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 64;
                end
                default:
                begin
                    tx_gap_pct = 20;
                    rx_stall_pct = 20;
                end
            endcase
            fill_random(390);
            wait_idle();
        end

        // back-pressure: sender keeps offering while the receiver holds off
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        fill_random(60);
        hold_go = 1'b1;
        wait_idle();

        // catch any stray results
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("serial_port_register_block_core_tb OK");
        else
            $display("serial_port_register_block_core_tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("serial_port_register_block_core_tb NOT OK");
        $finish;
    end

endmodule
